FILE: rtl/core/rcdm_pkg.sv
// ----------------------------------------------------------------------------
// rcdm_pkg: shared constants and types of the RC differential drive mixer
// Fixed-point widths, stick scaling reciprocals, register indexes and the
// configuration bundles handed to the stick and motor units.
// ----------------------------------------------------------------------------
package rcdm_pkg;

    // Stick fractions carry this many fraction bits: 1 << FRACTION_BITS is 1.0
    localparam int FRACTION_BITS = 10;

    localparam int CH_W  = 11;  // receiver channel width
    localparam int DZ_W  = 8;   // deadzone register width
    localparam int CMD_W = 12;  // signed motor command width

    localparam logic [CH_W-1:0] STICK_MIN    = 11'd172;
    localparam logic [CH_W-1:0] STICK_MAX    = 11'd1811;
    localparam logic [CH_W-1:0] STICK_CENTER = 11'd992;

    // Scaling spans of the two stick halves
    localparam int NEG_SPAN = int'(STICK_CENTER) - int'(STICK_MIN);
    localparam int POS_SPAN = int'(STICK_MAX) - int'(STICK_CENTER);

    // Distance from centre, its shifted dividend and the reciprocal divider
    localparam int MAG_W  = CH_W;
    localparam int X_W    = MAG_W + FRACTION_BITS;
    localparam int SH     = X_W + 1;
    localparam int REC_W  = SH - 9;
    localparam int PROD_W = X_W + REC_W;
    localparam int Q_W    = PROD_W - SH;
    localparam int F_W    = Q_W + 1;
    localparam int SUM_W  = F_W + 1;
    localparam int SPD_W  = FRACTION_BITS + 1;
    localparam int GP_W   = SPD_W + CH_W;

    localparam logic [REC_W-1:0] RECIP_NEG = REC_W'((64'd1 << SH) / NEG_SPAN);
    localparam logic [REC_W-1:0] RECIP_POS = REC_W'((64'd1 << SH) / POS_SPAN);

    // Pipeline depth, input to output register
    localparam int NUM_STAGES = 6;

    // Stream word widths, whole bytes
    localparam int IN_FIELDS_W  = 3 * CH_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * CMD_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = CH_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_DEADZONE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_CMD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_REV  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_REV = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ARM_THR   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_CH_LOW    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_CH_HIGH   = 3'd7;

    localparam logic [DZ_W-1:0] RST_DEADZONE  = 8'd20;
    localparam logic [CH_W-1:0] RST_GAIN      = 11'd200;
    localparam logic [CH_W-1:0] RST_MIN_CMD   = 11'd250;
    localparam logic            RST_LEFT_REV  = 1'b0;
    localparam logic            RST_RIGHT_REV = 1'b1;
    localparam logic [CH_W-1:0] RST_ARM_THR   = 11'd1500;
    localparam logic [CH_W-1:0] RST_CH_LOW    = 11'd172;
    localparam logic [CH_W-1:0] RST_CH_HIGH   = 11'd1811;

    typedef struct packed {
        logic [DZ_W-1:0] deadzone;
        logic [CH_W-1:0] ch_low;
        logic [CH_W-1:0] ch_high;
    } t_stick_cfg;

    typedef struct packed {
        logic [CH_W-1:0] gain;
        logic [CH_W-1:0] min_cmd;
        logic            reverse;
    } t_motor_cfg;

endpackage

FILE: rtl/core/rcdm_stick_scale.sv
// ----------------------------------------------------------------------------
// rcdm_stick_scale: stick channel to signed fraction
// Three stages: clamp and deadzone, reciprocal multiply, quotient
// correction and sign. Each stage loads when its enable is high.
// ----------------------------------------------------------------------------
module rcdm_stick_scale (
    input  logic                                i_clk,
    input  logic [2:0]                          i_en,
    input  rcdm_pkg::t_stick_cfg                i_cfg,
    input  logic [rcdm_pkg::CH_W-1:0]           i_raw,
    output logic signed [rcdm_pkg::F_W-1:0]     o_frac
);
    import rcdm_pkg::*;

    logic [CH_W-1:0]        lo_v;
    logic [CH_W-1:0]        cl_v;
    logic signed [CH_W:0]   ctr_offs;
    logic [MAG_W-1:0]       offs_mag;

    logic [MAG_W-1:0]       r_s1_mag;
    logic                   r_s1_neg;
    logic                   r_s1_zero;

    logic [X_W-1:0]         x1;
    logic [REC_W-1:0]       recip;
    logic [PROD_W-1:0]      n_s2_prod;
    logic [PROD_W-1:0]      r_s2_prod;
    logic [X_W-1:0]         r_s2_x;
    logic                   r_s2_neg;
    logic                   r_s2_zero;

    logic [Q_W-1:0]         q_est;
    logic [X_W-1:0]         span;
    logic [X_W-1:0]         qk;
    logic [X_W-1:0]         rem;
    logic [Q_W-1:0]         q;
    logic signed [F_W-1:0]  n_s3_frac;
    logic signed [F_W-1:0]  r_s3_frac;

    // Stage 1: clamp (high bound wins), offset from centre, deadzone
    always_comb begin
        lo_v     = (i_raw < i_cfg.ch_low) ? i_cfg.ch_low : i_raw;
        cl_v     = (lo_v > i_cfg.ch_high) ? i_cfg.ch_high : lo_v;
        ctr_offs = $signed({1'b0, cl_v}) - $signed({1'b0, STICK_CENTER});
        offs_mag = ctr_offs[CH_W] ? MAG_W'(-ctr_offs) : MAG_W'(ctr_offs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_mag  <= offs_mag;
            r_s1_neg  <= ctr_offs[CH_W];
            r_s1_zero <= (offs_mag < MAG_W'(i_cfg.deadzone));
        end
    end

    // Stage 2: multiply by reciprocal of the span of this half
    always_comb begin
        x1        = {r_s1_mag, {FRACTION_BITS{1'b0}}};
        recip     = r_s1_neg ? RECIP_NEG : RECIP_POS;
        n_s2_prod = {{REC_W{1'b0}}, x1} * {{X_W{1'b0}}, recip};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2_prod <= n_s2_prod;
            r_s2_x    <= x1;
            r_s2_neg  <= r_s1_neg;
            r_s2_zero <= r_s1_zero;
        end
    end

    // Stage 3: estimate is low by at most one, one compare fixes it
    always_comb begin
        q_est = r_s2_prod[PROD_W-1 -: Q_W];
        span  = r_s2_neg ? X_W'(NEG_SPAN) : X_W'(POS_SPAN);
        qk    = X_W'(X_W'(q_est) * span);
        rem   = r_s2_x - qk;
        q     = q_est + Q_W'(rem >= span);
        if (r_s2_zero) begin
            n_s3_frac = '0;
        end else if (r_s2_neg) begin
            n_s3_frac = -$signed({1'b0, q});
        end else begin
            n_s3_frac = $signed({1'b0, q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s3_frac <= n_s3_frac;
        end
    end

    assign o_frac = r_s3_frac;

endmodule

FILE: rtl/core/rcdm_motor_cmd.sv
// ----------------------------------------------------------------------------
// rcdm_motor_cmd: mix, clamp, gain and minimum for one motor side
// Two stages: mix and clamp to +-1.0, then gain multiply. The final
// shift, minimum raise and sign are combinational from the product.
// ----------------------------------------------------------------------------
module rcdm_motor_cmd (
    input  logic                                i_clk,
    input  logic [1:0]                          i_en,
    input  rcdm_pkg::t_motor_cfg                i_cfg,
    input  logic                                i_sub,
    input  logic signed [rcdm_pkg::F_W-1:0]     i_fwd,
    input  logic signed [rcdm_pkg::F_W-1:0]     i_trn,
    output logic signed [rcdm_pkg::CMD_W-1:0]   o_cmd
);
    import rcdm_pkg::*;

    localparam logic signed [SUM_W-1:0] ONE_P = SUM_W'(1 << FRACTION_BITS);
    localparam logic signed [SUM_W-1:0] ONE_M = -ONE_P;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] spd;
    logic [SPD_W-1:0]        spd_mag;

    logic [SPD_W-1:0]        r_s4_mag;
    logic                    r_s4_neg;

    logic [GP_W-1:0]         n_s5_prod;
    logic [GP_W-1:0]         r_s5_prod;
    logic                    r_s5_neg;

    logic [CMD_W-1:0]        mag;
    logic [CMD_W-1:0]        min_ext;
    logic [CMD_W-1:0]        raised;

    // Stage 4: mix, clamp to +-1.0, split into magnitude and sign
    always_comb begin
        if (i_sub) begin
            sum = SUM_W'(i_fwd) - SUM_W'(i_trn);
        end else begin
            sum = SUM_W'(i_fwd) + SUM_W'(i_trn);
        end
        if (sum > ONE_P) begin
            spd = ONE_P;
        end else if (sum < ONE_M) begin
            spd = ONE_M;
        end else begin
            spd = sum;
        end
        spd_mag = spd[SUM_W-1] ? SPD_W'(-spd) : SPD_W'(spd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s4_mag <= spd_mag;
            r_s4_neg <= spd[SUM_W-1] ^ i_cfg.reverse;
        end
    end

    // Stage 5: gain multiply
    assign n_s5_prod = {{CH_W{1'b0}}, r_s4_mag} * {{SPD_W{1'b0}}, i_cfg.gain};

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s5_prod <= n_s5_prod;
            r_s5_neg  <= r_s4_neg;
        end
    end

    // Truncate, raise small nonzero commands, apply the sign
    always_comb begin
        mag     = r_s5_prod[FRACTION_BITS +: CMD_W];
        min_ext = {1'b0, i_cfg.min_cmd};
        raised  = ((mag != '0) && (mag < min_ext)) ? min_ext : mag;
        o_cmd   = r_s5_neg ? $signed(CMD_W'(0) - raised) : $signed(raised);
    end

endmodule

FILE: rtl/core/rc_differential_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// rc_differential_drive_mixer_top: RC stick to differential drive mixer
// Turns one receiver frame into left and right motor commands.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one word per receiver frame, tdata carries forward_raw,
//   turn_raw and arm_raw. Master stream: one word per frame, tdata carries
//   left_command, right_command and armed.
//   The configuration port writes one register per cycle when i_cfg_we is
//   high; change it only while no frame is in flight.
//   Throughput: one word per cycle while the receiver takes words; the
//   six-stage pipeline is clamp, reciprocal multiply, quotient fix, mix,
//   gain multiply, output register.
//   Each stage has its own valid bit and loads when it is empty or the
//   stage after it moves, so bubbles close up under a stall and input is
//   still taken while a result waits at the output.
//   When the receiver stalls, the output word holds until taken; once the
//   pipeline is full, o_s_axis_tready drops.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   default register values; nothing is output until a word is accepted.
// ----------------------------------------------------------------------------
module rc_differential_drive_mixer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream, tdata: forward_raw[10:0], turn_raw[21:11], arm_raw[32:22]
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [rcdm_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // master stream, tdata: left_command[11:0], right_command[23:12], armed[24]
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [rcdm_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [rcdm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rcdm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import rcdm_pkg::*;

    logic [DZ_W-1:0]            r_deadzone;
    logic [CH_W-1:0]            r_gain;
    logic [CH_W-1:0]            r_min_cmd;
    logic                       r_left_rev;
    logic                       r_right_rev;
    logic [CH_W-1:0]            r_arm_thr;
    logic [CH_W-1:0]            r_ch_low;
    logic [CH_W-1:0]            r_ch_high;

    logic [NUM_STAGES-1:0]      r_vld;
    logic [NUM_STAGES-1:0]      en;
    logic [NUM_STAGES-2:0]      r_arm;

    logic [CH_W-1:0]            in_fwd;
    logic [CH_W-1:0]            in_trn;
    logic [CH_W-1:0]            in_arm;

    t_stick_cfg                 stick_cfg;
    t_motor_cfg                 left_cfg;
    t_motor_cfg                 right_cfg;

    logic signed [F_W-1:0]      fwd_frac;
    logic signed [F_W-1:0]      trn_frac;
    logic signed [CMD_W-1:0]    left_cmd;
    logic signed [CMD_W-1:0]    right_cmd;

    logic signed [CMD_W-1:0]    r_out_left;
    logic signed [CMD_W-1:0]    r_out_right;
    logic                       r_out_armed;

    assign in_fwd = i_s_axis_tdata[CH_W-1:0];
    assign in_trn = i_s_axis_tdata[2*CH_W-1:CH_W];
    assign in_arm = i_s_axis_tdata[3*CH_W-1:2*CH_W];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone  <= RST_DEADZONE;
            r_gain      <= RST_GAIN;
            r_min_cmd   <= RST_MIN_CMD;
            r_left_rev  <= RST_LEFT_REV;
            r_right_rev <= RST_RIGHT_REV;
            r_arm_thr   <= RST_ARM_THR;
            r_ch_low    <= RST_CH_LOW;
            r_ch_high   <= RST_CH_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEADZONE:  r_deadzone  <= i_cfg_wdata[DZ_W-1:0];
                CFG_GAIN:      r_gain      <= i_cfg_wdata;
                CFG_MIN_CMD:   r_min_cmd   <= i_cfg_wdata;
                CFG_LEFT_REV:  r_left_rev  <= i_cfg_wdata[0];
                CFG_RIGHT_REV: r_right_rev <= i_cfg_wdata[0];
                CFG_ARM_THR:   r_arm_thr   <= i_cfg_wdata;
                CFG_CH_LOW:    r_ch_low    <= i_cfg_wdata;
                CFG_CH_HIGH:   r_ch_high   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign stick_cfg = '{deadzone: r_deadzone, ch_low: r_ch_low, ch_high: r_ch_high};
    assign left_cfg  = '{gain: r_gain, min_cmd: r_min_cmd, reverse: r_left_rev};
    assign right_cfg = '{gain: r_gain, min_cmd: r_min_cmd, reverse: r_right_rev};

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];

    // Valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Arm decision rides alongside the stick pipeline
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_arm[0] <= (in_arm > r_arm_thr);
        end
        for (int k = 1; k < NUM_STAGES - 1; k++) begin
            if (en[k]) begin
                r_arm[k] <= r_arm[k-1];
            end
        end
    end

    rcdm_stick_scale u_fwd (
        .i_clk  (i_clk),
        .i_en   (en[2:0]),
        .i_cfg  (stick_cfg),
        .i_raw  (in_fwd),
        .o_frac (fwd_frac)
    );

    rcdm_stick_scale u_trn (
        .i_clk  (i_clk),
        .i_en   (en[2:0]),
        .i_cfg  (stick_cfg),
        .i_raw  (in_trn),
        .o_frac (trn_frac)
    );

    rcdm_motor_cmd u_left (
        .i_clk  (i_clk),
        .i_en   (en[4:3]),
        .i_cfg  (left_cfg),
        .i_sub  (1'b1),
        .i_fwd  (fwd_frac),
        .i_trn  (trn_frac),
        .o_cmd  (left_cmd)
    );

    rcdm_motor_cmd u_right (
        .i_clk  (i_clk),
        .i_en   (en[4:3]),
        .i_cfg  (right_cfg),
        .i_sub  (1'b0),
        .i_fwd  (fwd_frac),
        .i_trn  (trn_frac),
        .o_cmd  (right_cmd)
    );

    // Output register, commands forced to zero when disarmed
    always_ff @(posedge i_clk) begin
        if (en[NUM_STAGES-1]) begin
            r_out_left  <= r_arm[NUM_STAGES-2] ? left_cmd  : '0;
            r_out_right <= r_arm[NUM_STAGES-2] ? right_cmd : '0;
            r_out_armed <= r_arm[NUM_STAGES-2];
        end
    end

    assign o_m_axis_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                              r_out_armed, r_out_right, r_out_left};

endmodule

FILE: rtl/core/rcdm_checker.sv
// ----------------------------------------------------------------------------
// rcdm_checker: port-level checks of the mixer
// Watches the master stream and reset; bound to the top level below.
// ----------------------------------------------------------------------------
module rcdm_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [rcdm_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import rcdm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_MOST_NEG = {1'b1, {(CMD_W - 1){1'b0}}};

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    // Disarmed words carry zero commands
    a_disarmed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[2*CMD_W])
        |-> (o_m_axis_tdata[2*CMD_W-1:0] == '0))
        else $error("nonzero command while disarmed");

    // Command magnitudes stay within the channel range
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[CMD_W-1:0] != CMD_MOST_NEG)
                          && (o_m_axis_tdata[2*CMD_W-1:CMD_W] != CMD_MOST_NEG)))
        else $error("command outside its range");

    // A stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output word changed under stall");

endmodule

bind rc_differential_drive_mixer_top rcdm_checker u_rcdm_checker (.*);

FILE: dv/tb_rc_differential_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// tb_rc_differential_drive_mixer_top: self-checking bench for the drive mixer
// Sends receiver frames over the slave stream and checks every motor command
// word against a built-in predictor of the stick scaling, mix and gain path.
// Runs a directed set, then random frames under a series of register
// settings, with random gaps and stalls on both streams and one long stall.
// ----------------------------------------------------------------------------
module tb_rc_differential_drive_mixer_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = rcdm_pkg::FRACTION_BITS;
    localparam int MID_STICK  = 992;
    localparam int LOW_SPAN   = 820;    // 172..992
    localparam int HIGH_SPAN  = 819;    // 992..1811
    localparam int LONG_HOLD  = 300;    // cycles of the long receiver stall
    localparam int SETTLE     = 12;     // beyond the six-stage latency

    // One receiver frame, forward in the lowest bits
    typedef struct packed {
        logic [10:0] arm;
        logic [10:0] turn;
        logic [10:0] fwd;
    } t_rx_frame;

    // One motor command word, left command in the lowest bits
    typedef struct packed {
        logic        armed;
        logic [11:0] right_cmd;
        logic [11:0] left_cmd;
    } t_motor_word;

    typedef struct {
        logic [7:0]  deadzone;
        logic [10:0] gain;
        logic [10:0] min_cmd;
        logic        left_rev;
        logic        right_rev;
        logic [10:0] arm_thr;
        logic [10:0] ch_low;
        logic [10:0] ch_high;
    } t_mixer_cfg;

    logic                               i_clk           = 1'b0;
    logic                               i_rst_n         = 1'b0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    logic [rcdm_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata  = '0;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    logic [rcdm_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata;
    logic                               i_cfg_we        = 1'b0;
    logic [rcdm_pkg::CFG_ADDR_W-1:0]    i_cfg_addr      = '0;
    logic [rcdm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata     = '0;

    rc_differential_drive_mixer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Bench state
    t_rx_frame   frame_q[$];        // frames waiting to be sent
    t_motor_word cmd_expect_q[$];   // predicted command words, oldest first
    t_mixer_cfg  drive_cfg;         // bench copy of the register file
    int          mismatches    = 0;
    bit          in_word_taken = 1'b0;
    bit          calm          = 1'b0;  // no new gaps or stalls when set
    int          gap_cnt       = 0;
    int          gap_quiet     = 0;
    int          stall_cnt     = 0;
    int          stall_quiet   = 0;
    int          hold_cnt      = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Clamp, deadzone and piecewise scale of one stick to a signed fraction
    function automatic int stick_fraction_q(logic [10:0] raw, t_mixer_cfg c);
        int v;
        int offs;
        int mag;
        v = int'(raw);
        if (v < int'(c.ch_low))  v = int'(c.ch_low);
        if (v > int'(c.ch_high)) v = int'(c.ch_high);
        offs = v - MID_STICK;
        mag  = (offs < 0) ? -offs : offs;
        if (mag < int'(c.deadzone)) return 0;
        if (offs < 0) return -((mag << FRAC_BITS) / LOW_SPAN);
        return (mag << FRAC_BITS) / HIGH_SPAN;
    endfunction

    // Limit to +-1.0, apply gain, direction and the minimum command
    function automatic logic [11:0] motor_cmd_q(int speed, logic rev, t_mixer_cfg c);
        int   unity;
        int   mag;
        logic neg;
        unity = 1 << FRAC_BITS;
        if (speed > unity)  speed = unity;
        if (speed < -unity) speed = -unity;
        neg = (speed < 0);
        mag = neg ? -speed : speed;
        mag = (mag * int'(c.gain)) >> FRAC_BITS;
        if (rev) neg = !neg;
        if (mag != 0 && mag < int'(c.min_cmd)) mag = int'(c.min_cmd);
        if (neg) mag = -mag;
        return mag[11:0];
    endfunction

    function automatic t_motor_word mix_frame(t_rx_frame f, t_mixer_cfg c);
        t_motor_word w;
        int fwd_q;
        int turn_q;
        w = '0;
        if (f.arm <= c.arm_thr) return w;
        fwd_q  = stick_fraction_q(f.fwd, c);
        turn_q = stick_fraction_q(f.turn, c);
        w.left_cmd  = motor_cmd_q(fwd_q - turn_q, c.left_rev, c);
        w.right_cmd = motor_cmd_q(fwd_q + turn_q, c.right_rev, c);
        w.armed     = 1'b1;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one word per frame, random gap bursts between words
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic                            nxt_valid;
        logic [rcdm_pkg::IN_TDATA_W-1:0] nxt_data;
        nxt_valid = i_s_axis_tvalid;
        nxt_data  = i_s_axis_tdata;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_s_axis_tvalid || in_word_taken) begin
            nxt_valid = 1'b0;
            if (gap_cnt > 0) begin
                gap_cnt--;
            end else if (frame_q.size() > 0) begin
                nxt_valid = 1'b1;
                nxt_data  = rcdm_pkg::IN_TDATA_W'(frame_q.pop_front());
                if (!calm) begin
                    if (gap_quiet > 0)
                        gap_quiet--;
                    else if ($urandom_range(0, 1) == 0)
                        gap_cnt = $urandom_range(1, 19);
                    else
                        gap_quiet = $urandom_range(3, 40);
                end
            end
        end
        i_s_axis_tvalid <= nxt_valid;
        i_s_axis_tdata  <= nxt_data;
    end

    // ------------------------------------------------------------------------
    // Receiver ready: stall bursts, quiet stretches and the long hold-off
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_cnt    = LONG_HOLD;
        end
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            nxt_ready = 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            nxt_ready = 1'b0;
        end else if (stall_quiet > 0) begin
            stall_quiet--;
        end else if (!calm) begin
            if ($urandom_range(0, 1) == 0)
                stall_cnt = $urandom_range(1, 19);
            else
                stall_quiet = $urandom_range(5, 60);
        end
        i_m_axis_tready <= nxt_ready;
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input t_motor_word want,
                                 input t_motor_word got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected L=%0d R=%0d armed=%0b, got L=%0d R=%0d armed=%0b",
                     $realtime, what, $signed(want.left_cmd), $signed(want.right_cmd),
                     want.armed, $signed(got.left_cmd), $signed(got.right_cmd), got.armed);
    endtask

    always @(posedge i_clk) begin
        t_motor_word got;
        t_motor_word want;
        in_word_taken = ((i_rst_n && i_s_axis_tvalid && o_s_axis_tready) === 1'b1);
        if (in_word_taken)
            cmd_expect_q.push_back(mix_frame(t_rx_frame'(i_s_axis_tdata[32:0]), drive_cfg));
        if ((i_rst_n && o_m_axis_tvalid && i_m_axis_tready) === 1'b1) begin
            got = t_motor_word'(o_m_axis_tdata[24:0]);
            if (cmd_expect_q.size() == 0) begin
                note_mismatch("word with nothing expected", '0, got);
            end else begin
                want = cmd_expect_q.pop_front();
                if (got.left_cmd !== want.left_cmd || got.right_cmd !== want.right_cmd ||
                        got.armed !== want.armed)
                    note_mismatch("command mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_frame(input int fwd, input int turn, input int arm);
        t_rx_frame f;
        f.fwd  = fwd[10:0];
        f.turn = turn[10:0];
        f.arm  = arm[10:0];
        frame_q.push_back(f);
    endtask

    // Keep within the 11-bit channel range
    function automatic int chan_limit(int v);
        if (v < 0)    return 0;
        if (v > 2047) return 2047;
        return v;
    endfunction

    // Stick value aimed at the interesting regions of the current setting
    function automatic int rand_stick(t_mixer_cfg c);
        int dz;
        dz = int'(c.deadzone);
        case ($urandom_range(0, 5))
            0, 1: return $urandom_range(0, 2047);
            2:    return chan_limit(MID_STICK + $urandom_range(0, 2 * dz + 4) - dz - 2);
            3:    return chan_limit(int'(c.ch_low) + $urandom_range(0, 6) - 3);
            4:    return chan_limit(int'(c.ch_high) + $urandom_range(0, 6) - 3);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 0;
                    1:       return 2047;
                    2:       return 172;
                    3:       return 1811;
                    default: return MID_STICK;
                endcase
            end
        endcase
    endfunction

    // Arm value: mostly armed so the stick path is exercised
    function automatic int rand_arm(t_mixer_cfg c);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 2047);
            1:       return int'(c.arm_thr);
            2:       return chan_limit(int'(c.arm_thr) + 1);
            default: begin
                if (c.arm_thr == 11'd2047) return $urandom_range(0, 2047);
                return $urandom_range(int'(c.arm_thr) + 1, 2047);
            end
        endcase
    endfunction

    task automatic push_random(input int count);
        repeat (count)
            push_frame(rand_stick(drive_cfg), rand_stick(drive_cfg), rand_arm(drive_cfg));
    endtask

    task automatic write_reg(input logic [rcdm_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [rcdm_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            rcdm_pkg::CFG_DEADZONE:  drive_cfg.deadzone  = val[7:0];
            rcdm_pkg::CFG_GAIN:      drive_cfg.gain      = val;
            rcdm_pkg::CFG_MIN_CMD:   drive_cfg.min_cmd   = val;
            rcdm_pkg::CFG_LEFT_REV:  drive_cfg.left_rev  = val[0];
            rcdm_pkg::CFG_RIGHT_REV: drive_cfg.right_rev = val[0];
            rcdm_pkg::CFG_ARM_THR:   drive_cfg.arm_thr   = val;
            rcdm_pkg::CFG_CH_LOW:    drive_cfg.ch_low    = val;
            rcdm_pkg::CFG_CH_HIGH:   drive_cfg.ch_high   = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_mixer_cfg s);
        write_reg(rcdm_pkg::CFG_DEADZONE,  11'(s.deadzone));
        write_reg(rcdm_pkg::CFG_GAIN,      s.gain);
        write_reg(rcdm_pkg::CFG_MIN_CMD,   s.min_cmd);
        write_reg(rcdm_pkg::CFG_LEFT_REV,  11'(s.left_rev));
        write_reg(rcdm_pkg::CFG_RIGHT_REV, 11'(s.right_rev));
        write_reg(rcdm_pkg::CFG_ARM_THR,   s.arm_thr);
        write_reg(rcdm_pkg::CFG_CH_LOW,    s.ch_low);
        write_reg(rcdm_pkg::CFG_CH_HIGH,   s.ch_high);
    endtask

    function automatic t_mixer_cfg rand_settings();
        t_mixer_cfg s;
        s.deadzone  = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 60));
        s.gain      = 11'($urandom_range(0, 2047));
        s.min_cmd   = 11'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 400));
        s.left_rev  = 1'($urandom_range(0, 1));
        s.right_rev = 1'($urandom_range(0, 1));
        s.arm_thr   = 11'($urandom_range(0, 1800));
        s.ch_low    = ($urandom_range(0, 1) == 0) ? 11'd172 : 11'($urandom_range(0, 400));
        s.ch_high   = ($urandom_range(0, 1) == 0) ? 11'd1811 : 11'($urandom_range(1500, 2047));
        return s;
    endfunction

    // Idle means all frames sent and every predicted word received
    task automatic wait_drained();
        while (frame_q.size() != 0 || i_s_axis_tvalid || cmd_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        t_mixer_cfg s;
        drive_cfg.deadzone  = rcdm_pkg::RST_DEADZONE;
        drive_cfg.gain      = rcdm_pkg::RST_GAIN;
        drive_cfg.min_cmd   = rcdm_pkg::RST_MIN_CMD;
        drive_cfg.left_rev  = rcdm_pkg::RST_LEFT_REV;
        drive_cfg.right_rev = rcdm_pkg::RST_RIGHT_REV;
        drive_cfg.arm_thr   = rcdm_pkg::RST_ARM_THR;
        drive_cfg.ch_low    = rcdm_pkg::RST_CH_LOW;
        drive_cfg.ch_high   = rcdm_pkg::RST_CH_HIGH;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed frames under the reset settings
        push_frame(992, 992, 0);        // disarmed, arm at zero
        push_frame(2047, 0, 1500);      // arm exactly at threshold: disarmed
        push_frame(2047, 992, 1501);    // just armed, full forward
        push_frame(0, 992, 2047);       // full reverse, clamped from below
        push_frame(992, 2047, 2047);    // full turn right
        push_frame(992, 0, 2047);       // full turn left
        push_frame(2047, 2047, 2047);   // mix saturates one side
        push_frame(0, 0, 2047);
        push_frame(172, 1811, 1800);
        push_frame(1811, 172, 1800);
        push_frame(1011, 973, 1800);    // just inside the deadzone both sides
        push_frame(1012, 972, 1800);    // just outside the deadzone
        push_frame(972, 992, 1800);
        push_frame(1012, 992, 1800);
        push_frame(1020, 992, 1800);    // small speed raised to the minimum
        push_frame(960, 992, 1800);
        push_frame(1100, 1100, 1800);   // left zero, right nonzero
        push_frame(11'h555, 11'h2AA, 11'h7FF);
        push_frame(11'h2AA, 11'h555, 11'h555);
        push_frame(171, 1812, 1700);    // just beyond the channel range
        push_frame(992, 992, 2047);     // centred sticks, armed
        push_random(150);
        wait_drained();

        for (int phase = 1; phase <= 10; phase++) begin
            s = rand_settings();
            case (phase)
                1: begin
                    // No deadzone, wide clamp, full gain, no minimum
                    s.deadzone = 8'd0;  s.gain = 11'd2047; s.min_cmd = 11'd0;
                    s.left_rev = 1'b1;  s.right_rev = 1'b0;
                    s.arm_thr  = 11'd0; s.ch_low = 11'd0;  s.ch_high = 11'd2047;
                end
                2: begin
                    // Widest deadzone, zero gain, largest minimum
                    s.deadzone = 8'd255; s.gain = 11'd0; s.min_cmd = 11'd2047;
                    s.arm_thr  = 11'd1000;
                end
                3: begin
                    // Inverted clamp bounds
                    s.ch_low = 11'd1500; s.ch_high = 11'd600;
                end
                4: s.arm_thr = 11'd2047;   // never armed
                5: begin
                    s.gain = 11'd2047; s.min_cmd = 11'd2047;
                    s.ch_low = 11'd2047; s.ch_high = 11'd2047;
                end
                7: begin
                    s.ch_low = 11'd0; s.ch_high = 11'd0; s.left_rev = 1'b1; s.right_rev = 1'b1;
                end
                10: calm = 1'b1;
                default: ;
            endcase
            load_settings(s);
            push_random((phase == 4) ? 40 : (phase == 10) ? 160 : 200);
            // Long receiver stall while the sender keeps offering frames
            if (phase == 6) hold_requests++;
            wait_drained();
        end

        if (mismatches == 0 && cmd_expect_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
